// ===== src/tvp_pkg.sv =====
// Package for the trapezoidal velocity profile block.
// Holds field widths, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps

package tvp_pkg;

    // Field widths.
    localparam int unsigned POS_W   = 32;
    localparam int unsigned VEL_W   = 32;
    localparam int unsigned DT_W    = 16;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned CRIT_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_RANGE   = 2'd2;

    // Reset values.
    localparam logic [LIMIT_W-1:0] MAX_VELOCITY_RST = 31'd65536;
    localparam logic [LIMIT_W-1:0] MAX_ACCEL_RST    = 31'd65536;
    localparam logic [CRIT_W-1:0]  CRIT_RANGE_RST   = 16'd75;

    // The stop window never exceeds this many whole units.
    localparam logic [6:0] CRIT_CAP = 7'd75;

    // Serial step counts.
    localparam int unsigned MUL_STEPS  = 33;
    localparam int unsigned FRAC_STEPS = 17;

endpackage

// ===== src/trapezoidal_velocity_profile.sv =====
// Top level of the trapezoidal velocity profile block.
// Depends on tvp_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

// One tick in, one velocity command out. The transfer edge itself loads the
// operands, and the result is then worked out as follows. First, bit-serial
// shift-add units form v*v, a*|d| and a*dt while a restoring divider forms the
// 17-bit position fraction. Then a bit-serial multiply of that fraction by
// a*dt. Last, a step that combines the branches, saturates, limits and applies
// the stop window. The input is stalled from the transfer until the result has
// been loaded, so a new tick is not taken before the last one is in the output
// register. The result sits in an output register, so the next tick may be
// taken while it waits. A tick that finishes while that register is still full
// waits in its last state.
module trapezoidal_velocity_profile (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [tvp_pkg::POS_W-1:0]  i_current_position,
    input  logic signed [tvp_pkg::VEL_W-1:0]  i_current_velocity,
    input  logic signed [tvp_pkg::POS_W-1:0]  i_target_position,
    input  logic        [tvp_pkg::DT_W-1:0]   i_time_step,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [tvp_pkg::VEL_W-1:0]  o_velocity_command,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic        [tvp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [31:0]                i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_FRAC, S_DONE} t_state;

    t_state      r_state;
    logic [5:0]  r_cnt;

    // Configuration registers.
    logic [30:0] r_max_vel;
    logic [30:0] r_max_acc;
    logic [15:0] r_crit;

    // Stored command.
    logic signed [31:0] r_cmd;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_out_cmd;

    // Per-tick operands.
    logic [32:0] r_dabs;
    logic        r_d_pos;
    logic        r_vel_pos;
    logic [31:0] r_vabs;
    logic [32:0] r_den;

    // Serial units.
    logic [62:0] r_vsq;
    logic [31:0] r_vmul;
    logic [63:0] r_ad;
    logic [32:0] r_dmul;
    logic [46:0] r_p;
    logic [15:0] r_tmul;
    logic [33:0] r_rem;
    logic [16:0] r_q;
    logic [63:0] r_fp;
    logic [16:0] r_fmul;

    // Operand preparation at the transfer.
    logic signed [32:0] w_d;
    logic [32:0] w_dabs;
    logic [31:0] w_vabs;
    logic [31:0] w_pabs;
    logic [31:0] w_tabs;
    logic        w_same;
    logic [32:0] w_num;
    logic [32:0] w_den;

    always_comb begin
        w_d    = {i_target_position[31], i_target_position}
               - {i_current_position[31], i_current_position};
        w_dabs = w_d[32] ? 33'(-w_d) : 33'(w_d);
        w_vabs = i_current_velocity[31] ? 32'(-i_current_velocity)
                                        : 32'(i_current_velocity);
        w_pabs = i_current_position[31] ? 32'(-i_current_position)
                                        : 32'(i_current_position);
        w_tabs = i_target_position[31] ? 32'(-i_target_position)
                                       : 32'(i_target_position);
        w_same = (!i_current_position[31] && !i_target_position[31])
              || ((i_current_position[31] || i_current_position == '0)
                  && (i_target_position[31] || i_target_position == '0));
        if (w_same) begin
            if (w_tabs > w_pabs) begin
                w_num = {1'b0, w_pabs};
                w_den = {1'b0, w_tabs};
            end else begin
                w_num = {1'b0, w_tabs};
                w_den = {1'b0, w_pabs};
            end
        end else begin
            w_num = {1'b0, w_tabs};
            w_den = {1'b0, w_tabs} + {1'b0, w_pabs};
        end
    end

    // Divider step: no shift on the first step, since the numerator never
    // exceeds the divisor.
    logic [33:0] w_trial;
    logic        w_ge;
    always_comb begin
        w_trial = (r_cnt == '0) ? r_rem : {r_rem[32:0], 1'b0};
        w_ge    = w_trial >= {1'b0, r_den};
    end

    // Final combination of the accelerate and decelerate branches.
    logic [30:0]        w_step;
    logic [31:0]        w_m;
    logic [31:0]        w_cabs;
    logic               w_decel;
    logic               w_accel;
    logic signed [33:0] w_change;
    logic signed [33:0] w_sum;
    logic signed [31:0] n_cmd;
    logic [6:0]         w_win;

    always_comb begin
        w_step  = r_p[46:16];
        w_m     = r_fp[63:32];
        w_cabs  = r_cmd[31] ? 32'(-r_cmd) : 32'(r_cmd);
        // dabs <= floor(v*v / 2a) is the same as 2a*dabs <= v*v.
        w_decel = {r_ad, 1'b0} <= {2'b00, r_vsq};
        w_accel = (r_vabs < {1'b0, r_max_vel}) && (r_dabs != '0);
        w_change = '0;
        if (w_decel) begin
            if (w_m > w_cabs) begin
                w_change = -34'(signed'({{2{r_cmd[31]}}, r_cmd}));
            end else if (r_vel_pos) begin
                w_change = -34'(signed'({2'b00, w_m}));
            end else begin
                w_change = 34'(signed'({2'b00, w_m}));
            end
        end else if (w_accel) begin
            w_change = r_d_pos ? 34'(signed'({3'b000, w_step}))
                               : -34'(signed'({3'b000, w_step}));
        end
        w_sum = 34'(signed'({{2{r_cmd[31]}}, r_cmd})) + w_change;
        if (w_sum > 34'sh0_7FFF_FFFF) begin
            n_cmd = 32'sh7FFF_FFFF;
        end else if (w_sum < -34'sh0_8000_0000) begin
            n_cmd = 32'sh8000_0000;
        end else begin
            n_cmd = w_sum[31:0];
        end
        // Velocity limit, tested on the previous command's magnitude.
        if (w_cabs > {1'b0, r_max_vel}) begin
            n_cmd = (n_cmd > 0) ? 32'(signed'({1'b0, r_max_vel}))
                                : -32'(signed'({1'b0, r_max_vel}));
        end
        // Stop window.
        w_win = (r_crit < {9'b0, tvp_pkg::CRIT_CAP}) ? r_crit[6:0] : tvp_pkg::CRIT_CAP;
        if (r_dabs < {10'b0, w_win, 16'b0}) begin
            n_cmd = '0;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel <= tvp_pkg::MAX_VELOCITY_RST;
            r_max_acc <= tvp_pkg::MAX_ACCEL_RST;
            r_crit    <= tvp_pkg::CRIT_RANGE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tvp_pkg::CFG_MAX_VELOCITY: r_max_vel <= i_cfg_data[30:0];
                tvp_pkg::CFG_MAX_ACCEL:    r_max_acc <= i_cfg_data[30:0];
                tvp_pkg::CFG_CRIT_RANGE:   r_crit    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer, serial units and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cmd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the last cycle of a tick the output register is reloaded instead.
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dabs    <= w_dabs;
                        r_d_pos   <= !w_d[32] && (w_d != '0);
                        r_vel_pos <= !i_current_velocity[31]
                                     && (i_current_velocity != '0);
                        r_vabs    <= w_vabs;
                        r_den     <= w_den;
                        r_vsq     <= '0;
                        r_vmul    <= w_vabs;
                        r_ad      <= '0;
                        r_dmul    <= w_dabs;
                        r_p       <= '0;
                        r_tmul    <= i_time_step;
                        r_rem     <= {1'b0, w_num};
                        r_q       <= '0;
                        r_cnt     <= '0;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    // Shift-add multipliers, multiplier bits taken MSB first.
                    if (r_cnt < 6'd32) begin
                        r_vsq  <= {r_vsq[61:0], 1'b0}
                                + (r_vmul[31] ? {31'b0, r_vabs} : 63'b0);
                        r_vmul <= {r_vmul[30:0], 1'b0};
                    end
                    r_ad   <= {r_ad[62:0], 1'b0}
                            + (r_dmul[32] ? {33'b0, r_max_acc} : 64'b0);
                    r_dmul <= {r_dmul[31:0], 1'b0};
                    if (r_cnt < 6'd16) begin
                        r_p    <= {r_p[45:0], 1'b0}
                                + (r_tmul[15] ? {16'b0, r_max_acc} : 47'b0);
                        r_tmul <= {r_tmul[14:0], 1'b0};
                    end
                    // Restoring divider for the position fraction.
                    if (r_cnt < 6'(tvp_pkg::FRAC_STEPS)) begin
                        r_rem <= w_ge ? w_trial - {1'b0, r_den} : w_trial;
                        r_q   <= {r_q[15:0], w_ge};
                    end
                    if (r_cnt == 6'(tvp_pkg::MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_fp    <= '0;
                        r_fmul  <= (r_den == '0) ? 17'b0 : r_q;
                        r_state <= S_FRAC;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_FRAC: begin
                    // Fraction times a*dt.
                    r_fp   <= {r_fp[62:0], 1'b0}
                            + (r_fmul[16] ? {17'b0, r_p} : 64'b0);
                    r_fmul <= {r_fmul[15:0], 1'b0};
                    if (r_cnt == 6'(tvp_pkg::FRAC_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DONE: begin
                    // Load the result once the output register is free.
                    if (!r_out_valid || !i_out_stall) begin
                        r_cmd       <= n_cmd;
                        r_out_cmd   <= n_cmd;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_velocity_command = r_out_cmd;
    assign o_cfg_ready        = 1'b1;

endmodule

// ===== src/tvp_checker.sv =====
// Port-level checker for the trapezoidal velocity profile block.
// Depends only on the top level's ports; bound to it at the end of the file.
`timescale 1ns / 1ps

module tvp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_velocity_command
);

    // A transfer on the input starts a tick, which holds the input off.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // A new result only appears at the end of a tick in progress.
    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no tick in progress");

    // A stalled result stays offered and unchanged.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_velocity_command))
        else $error("stalled result changed or was dropped");

endmodule

bind trapezoidal_velocity_profile tvp_checker u_tvp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_velocity_command (o_velocity_command)
);

// ===== tb/sv/tb_trapezoidal_velocity_profile.sv =====
// Self-checking testbench for the trapezoidal velocity profile block.
// Depends on tvp_pkg and trapezoidal_velocity_profile; drives random ticks
// and register settings, and checks every command against its own predictor.
`timescale 1ns / 1ps

module tb_trapezoidal_velocity_profile;

    typedef struct {
        logic signed [tvp_pkg::POS_W-1:0] pos;
        logic signed [tvp_pkg::VEL_W-1:0] vel;
        logic signed [tvp_pkg::POS_W-1:0] tgt;
        logic [tvp_pkg::DT_W-1:0]         dt;
    } t_tick;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [tvp_pkg::POS_W-1:0] i_current_position = '0;
    logic signed [tvp_pkg::VEL_W-1:0] i_current_velocity = '0;
    logic signed [tvp_pkg::POS_W-1:0] i_target_position = '0;
    logic [tvp_pkg::DT_W-1:0] i_time_step = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [tvp_pkg::VEL_W-1:0] o_velocity_command;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [tvp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    // Predictor state and register copies.
    bit [63:0] vmax_model;
    bit [63:0] accel_model;
    bit [63:0] crit_model;
    longint cmd_model;

    t_tick pending_ticks[$];
    logic signed [tvp_pkg::VEL_W-1:0] expected_cmds[$];
    int errors = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;

    trapezoidal_velocity_profile u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_current_position(i_current_position),
        .i_current_velocity(i_current_velocity),
        .i_target_position(i_target_position), .i_time_step(i_time_step),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_velocity_command(o_velocity_command),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the next velocity command and advances the stored command.
    function automatic logic signed [tvp_pkg::VEL_W-1:0] predict_command(t_tick t);
        longint pos, vel, tgt, d, change, nxt;
        bit [63:0] dabs, vabs, pabs, tabs, cabs, stop, dtu, num, den, f, m, win;
        bit same;
        pos = t.pos;
        vel = t.vel;
        tgt = t.tgt;
        dtu = 64'(t.dt);
        d = tgt - pos;
        dabs = d < 0 ? 64'(-d) : 64'(d);
        vabs = vel < 0 ? 64'(-vel) : 64'(vel);
        pabs = pos < 0 ? 64'(-pos) : 64'(pos);
        tabs = tgt < 0 ? 64'(-tgt) : 64'(tgt);
        cabs = cmd_model < 0 ? 64'(-cmd_model) : 64'(cmd_model);
        change = 0;
        // Stopping distance v*v/(2a); a zero acceleration saturates it.
        if (accel_model == 0) stop = '1;
        else stop = (vabs * vabs) / (2 * accel_model);
        // Accelerate towards the target while below the speed limit.
        if (vabs < vmax_model && dabs > 0) begin
            change = longint'((accel_model * dtu) >> 16);
            if (d < 0) change = -change;
        end
        // Decelerate by a position-ratio fraction, never past zero.
        if (dabs <= stop) begin
            same = (pos >= 0 && tgt >= 0) || (pos <= 0 && tgt <= 0);
            if (!same) begin
                num = tabs;
                den = tabs + pabs;
            end else if (tabs > pabs) begin
                num = pabs;
                den = tabs;
            end else begin
                num = tabs;
                den = pabs;
            end
            f = (den != 0) ? (num << 16) / den : 64'd0;
            m = (f * accel_model * dtu) >> 32;
            change = vel > 0 ? -longint'(m) : longint'(m);
            if (m > cabs) change = -cmd_model;
        end
        nxt = cmd_model + change;
        if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
        if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
        // The limit is tested on the previous command's magnitude.
        if (cabs > vmax_model) nxt = nxt > 0 ? longint'(vmax_model) : -longint'(vmax_model);
        win = (crit_model < 75 ? crit_model : 64'd75) << 16;
        if (dabs < win) nxt = 0;
        cmd_model = nxt;
        return nxt[31:0];
    endfunction

    task automatic report_mismatch(input logic signed [tvp_pkg::VEL_W-1:0] got,
                                   input logic signed [tvp_pkg::VEL_W-1:0] want);
        $display("mismatch at %0t: velocity_command got %0d expected %0d", $realtime, got, want);
        errors++;
    endtask

    // Driver: bursts of transfers with random gaps; the payload holds while stalled.
    always @(posedge i_clk) begin
        t_tick t;
        logic nv;
        nv = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_cmds.push_back(predict_command(pending_ticks.pop_front()));
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 70);
                end
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    nv = 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    t = pending_ticks[0];
                    nv = 1'b1;
                    i_current_position <= t.pos;
                    i_current_velocity <= t.vel;
                    i_target_position <= t.tgt;
                    i_time_step <= t.dt;
                end else begin
                    nv = 1'b0;
                end
            end
        end
        i_in_valid <= nv;
    end

    // Receiver stall pattern, with one long hold-off so the block backs up.
    always @(posedge i_clk) begin
        logic st;
        rx_cycle++;
        if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
        if (rx_cycle == 6000) hold_left = 500;
        if (hold_left > 0) begin
            hold_left--;
            st = 1'b1;
        end else begin
            case (rx_mode)
                0: st = 1'b0;
                1: st = ($urandom_range(0, 3) == 0);
                2: st = ($urandom_range(0, 3) != 0);
                default: st = rx_cycle[0];
            endcase
        end
        i_out_stall <= st;
    end

    // Monitor: each result transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cmds.size() == 0) begin
                $display("unexpected result at %0t: %0d", $realtime, o_velocity_command);
                errors++;
            end else begin
                logic signed [tvp_pkg::VEL_W-1:0] want;
                want = expected_cmds.pop_front();
                if (o_velocity_command !== want) report_mismatch(o_velocity_command, want);
            end
        end
    end

    task automatic add_tick(input logic [31:0] p, input logic [31:0] v,
                            input logic [31:0] g, input logic [15:0] dt);
        t_tick t;
        t.pos = p;
        t.vel = v;
        t.tgt = g;
        t.dt = dt;
        pending_ticks.push_back(t);
    endtask

    // Random tick: mostly moves towards a target with plausible speeds, some noise.
    task automatic add_random_tick(input logic [31:0] goal);
        int unsigned kind;
        logic [31:0] off;
        logic [15:0] dt;
        kind = $urandom_range(0, 9);
        dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        off = $urandom_range(0, 32'h00FF_FFFF) >> $urandom_range(0, 16);
        if ($urandom_range(0, 1)) off = -off;
        if (kind < 6)
            add_tick(goal - off, 32'($signed(off)) >>> $urandom_range(0, 8), goal, dt);
        else if (kind < 8)
            add_tick(goal - ($urandom_range(0, 100) << 16), $urandom, goal, dt);
        else
            add_tick($urandom, $urandom, $urandom, 16'($urandom));
    endtask

    task automatic write_reg(input logic [tvp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == tvp_pkg::CFG_MAX_VELOCITY) vmax_model = 64'(data[30:0]);
        else if (idx == tvp_pkg::CFG_MAX_ACCEL) accel_model = 64'(data[30:0]);
        else if (idx == tvp_pkg::CFG_CRIT_RANGE) crit_model = 64'(data[15:0]);
    endtask

    // Waits for every transfer and result, then lets the block settle.
    task automatic drain();
        while (pending_ticks.size() > 0 || expected_cmds.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] goal;
        vmax_model = 64'(tvp_pkg::MAX_VELOCITY_RST);
        accel_model = 64'(tvp_pkg::MAX_ACCEL_RST);
        crit_model = 64'(tvp_pkg::CRIT_RANGE_RST);
        cmd_model = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks: field extremes, stop window, zero divisor, braking.
        add_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        add_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
        add_tick(0, 0, 0, 0);
        add_tick(32'h0010_0000, 0, 32'h0010_0000, 16'h8000);
        add_tick(0, 32'h0100_0000, 32'h0100_0000, 16'h4000);
        add_tick(32'h0064_0000, 32'h0001_0000, 32'h0200_0000, 16'hFFFF);
        add_tick(32'h0064_0000, 32'h0001_0000, 32'h0200_0000, 16'hFFFF);
        add_tick(32'h0064_0000, 32'h0100_0000, 32'h0080_0000, 16'h1000);
        add_tick(32'hFF00_0000, 32'h7FFF_FFFF, 32'h0100_0000, 16'hFFFF);
        add_tick(32'h0100_0000, 32'h8000_0001, 32'hFF00_0000, 16'hFFFF);
        add_tick(32'h0000_0001, 32'hFFFF_FFFF, 32'h004A_FFFF, 16'h0001);
        add_tick(32'h0000_0000, 32'h0000_0000, 32'h004B_0000, 16'h0100);
        add_tick(32'h1234_5678, 32'h0000_0000, 32'h1300_0000, 16'h5555);
        add_tick(32'hEDCB_A988, 32'h0002_0000, 32'hEC00_0000, 16'hAAAA);
        drain();

        // Phases through several register settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(tvp_pkg::CFG_MAX_VELOCITY, 32'h7FFF_FFFF);
                    write_reg(tvp_pkg::CFG_MAX_ACCEL, 32'h7FFF_FFFF);
                    write_reg(tvp_pkg::CFG_CRIT_RANGE, 32'd0);
                end
                2: begin
                    write_reg(tvp_pkg::CFG_MAX_VELOCITY, 32'd0);
                    write_reg(tvp_pkg::CFG_MAX_ACCEL, 32'd1);
                    write_reg(tvp_pkg::CFG_CRIT_RANGE, 32'h0000_FFFF);
                end
                3: begin
                    write_reg(tvp_pkg::CFG_MAX_VELOCITY, 32'h0040_0000);
                    write_reg(tvp_pkg::CFG_MAX_ACCEL, 32'h0010_0000);
                    write_reg(tvp_pkg::CFG_CRIT_RANGE, 32'd10);
                end
                default: begin
                    write_reg(tvp_pkg::CFG_MAX_VELOCITY, $urandom);
                    write_reg(tvp_pkg::CFG_MAX_ACCEL, $urandom_range(1, 32'h7FFF_FFFF));
                    write_reg(tvp_pkg::CFG_CRIT_RANGE, $urandom_range(0, 120));
                end
            endcase
            goal = $urandom;
            for (int n = 0; n < 156; n++) begin
                if ($urandom_range(0, 40) == 0) goal = $urandom;
                add_random_tick(goal);
            end
            // The sender pauses here until every command has come back.
            drain();
        end

        if (errors == 0)
            $display("tb_trapezoidal_velocity_profile: PASS");
        else
            $display("tb_trapezoidal_velocity_profile: FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_trapezoidal_velocity_profile: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/tvp_pkg.sv
src/trapezoidal_velocity_profile.sv
src/tvp_checker.sv
tb/sv/tb_trapezoidal_velocity_profile.sv
